// File: rtl/core/ctl_pkg.sv
`default_nettype none

package ctl_pkg;

    localparam int SETS      = 64;
    localparam int WAYS      = 4;
    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int ENTRY_AW  = SET_W + WAY_W;
    localparam int ENTRIES   = SETS * WAYS;

    localparam int ADDR_W    = 32;
    localparam int CNT_MOD_W = 7;
    localparam int BSL_W     = 4;

    // divider retires this many quotient bits per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = ADDR_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_COUNT     = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] tag;
        logic [2:0]        state;
        logic              prefetched;
        logic [ADDR_W-1:0] transient;
        logic              lock;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/ctl_div.sv
`default_nettype none

// Restoring divider, DIV_STEPS quotient bits per cycle. Only the low SET_W
// quotient bits are kept. A zero divisor divides as one.
module ctl_div
    import ctl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [ADDR_W-1:0]    dividend,
    input  wire logic [CNT_MOD_W-1:0] divisor,
    output logic                      done,
    output logic [SET_W-1:0]          quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ADDR_W-1:0]    dvd_reg;
    logic [CNT_MOD_W-1:0] dsr_reg;
    logic [CNT_MOD_W-1:0] rem_reg;
    logic [SET_W-1:0]     quot_reg;

    logic [ADDR_W-1:0]    dvd_next;
    logic [CNT_MOD_W-1:0] rem_next;
    logic [SET_W-1:0]     quot_next;

    always_comb
    begin
        logic [CNT_MOD_W:0] trial;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial    = {rem_next, dvd_next[ADDR_W-1]};
            dvd_next = {dvd_next[ADDR_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial     = trial - {1'b0, dsr_reg};
                quot_next = {quot_next[SET_W-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_next[SET_W-2:0], 1'b0};
            end
            rem_next = trial[CNT_MOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dsr_reg  <= (divisor == '0) ? CNT_MOD_W'(1) : divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= dvd_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: rtl/core/ctl_tag_store.sv
`default_nettype none

// Tag store: one write and one registered read per cycle. Per-entry valid
// flops make never-written entries read as zero.
module ctl_tag_store
    import ctl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [ENTRY_AW-1:0] wr_addr,
    input  wire entry_t              wr_data,
    input  wire logic                rd_en,
    input  wire logic [ENTRY_AW-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t             entry_mem_reg [ENTRIES];
    entry_t             rd_mem_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= entry_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire

// File: rtl/core/cache_tag_lookup_top.sv
`default_nettype none

// Channel   | Signals                                  | Role
// ----------+------------------------------------------+---------------------------
// s_axis    | tvalid tready tdata[80] tuser[1]         | lookup / entry write in
// m_axis    | tvalid tready tdata[48]                  | one result per item
// cfg       | cfg_valid cfg_ready cfg_index cfg_data   | register writes
//
// Entry write: idle goes straight to output. Lookup: a read and a compare state
// per way searched, after the 4-bit-per-cycle block divider in interleaved mode.
// One item in flight; s_axis_tready is high only while the sequencer idles.
// A finished result waits in the sequencer if the output register is still held.
// Reset clears the tag store valid flops at once: no clearing pass.
module cache_tag_lookup_top
    import ctl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // address[31:0] set_sel[37:32] way_sel[39:38] new_state[42:40]
    // new_prefetched[43] new_transient_tag[75:44] new_lock[76] zero[79:77]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // hit[0] set_index[6:1] block_tag[38:7] hit_way[40:39] block_state[43:41]
    // was_prefetched[44] zero[47:45]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [SET_W-1:0]        set_reg;
    logic [WAY_W-1:0]        way_reg;
    logic [ADDR_W-1:0]       tag_reg;
    logic                    res_hit_reg;
    logic [WAY_W-1:0]        res_way_reg;
    logic [2:0]              res_state_reg;
    logic                    res_pref_reg;
    logic                    m_valid_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    logic [BSL_W-1:0]        bsl_reg;
    logic                    interleaved_reg;
    logic [CNT_MOD_W-1:0]    mod_count_reg;

    logic                    in_acc;
    logic                    in_cmd;
    logic [ADDR_W-1:0]       in_addr;
    entry_t                  wr_entry;
    logic [ADDR_W-1:0]       lk_mask;
    logic [ADDR_W-1:0]       lk_tag;
    logic [ADDR_W-1:0]       lk_blk;
    logic                    wr_en;
    logic                    div_start;
    logic                    div_done;
    logic [SET_W-1:0]        div_quot;
    logic                    rd_en;
    entry_t                  rd_data;
    logic                    way_match;
    logic                    out_free;

    assign in_cmd  = s_axis_tuser[0];
    assign in_addr = s_axis_tdata[31:0];

    assign wr_entry.tag        = in_addr;
    assign wr_entry.state      = s_axis_tdata[42:40];
    assign wr_entry.prefetched = s_axis_tdata[43];
    assign wr_entry.transient  = s_axis_tdata[75:44];
    assign wr_entry.lock       = s_axis_tdata[76];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign lk_mask = (ADDR_W'(1) << bsl_reg) - ADDR_W'(1);
    assign lk_tag  = in_addr & ~lk_mask;
    assign lk_blk  = lk_tag >> bsl_reg;

    assign wr_en     = in_acc && (in_cmd == CMD_WRITE);
    assign div_start = in_acc && (in_cmd == CMD_LOOKUP) && interleaved_reg;
    assign rd_en     = (state_reg == ST_RD);

    assign way_match = ((rd_data.tag == tag_reg) && (rd_data.state != '0))
                    || ((rd_data.transient == tag_reg) && rd_data.lock);

    assign out_free = !m_valid_reg || m_axis_tready;

    ctl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lk_blk),
        .divisor  (mod_count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    ctl_tag_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr ({s_axis_tdata[37:32], s_axis_tdata[39:38]}),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr ({set_reg, way_reg}),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            set_reg       <= '0;
            way_reg       <= '0;
            tag_reg       <= '0;
            res_hit_reg   <= 1'b0;
            res_way_reg   <= '0;
            res_state_reg <= '0;
            res_pref_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end
        else
        begin
            // in ST_OUT the output register is reloaded below instead
            if (m_valid_reg && m_axis_tready && (state_reg != ST_OUT))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        res_hit_reg   <= 1'b0;
                        res_way_reg   <= '0;
                        res_state_reg <= '0;
                        res_pref_reg  <= 1'b0;
                        way_reg       <= '0;
                        if (in_cmd == CMD_WRITE)
                        begin
                            // write acknowledge carries all-zero fields
                            tag_reg   <= '0;
                            set_reg   <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            tag_reg <= lk_tag;
                            if (interleaved_reg)
                            begin
                                state_reg <= ST_DIV;
                            end
                            else
                            begin
                                set_reg   <= lk_blk[SET_W-1:0];
                                state_reg <= ST_RD;
                            end
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        set_reg   <= div_quot;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (way_match)
                    begin
                        res_hit_reg   <= 1'b1;
                        res_way_reg   <= way_reg;
                        res_state_reg <= rd_data.state;
                        res_pref_reg  <= rd_data.prefetched;
                        state_reg     <= ST_OUT;
                    end
                    else if (way_reg == WAY_W'(WAYS - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        way_reg   <= way_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'b000, res_pref_reg, res_state_reg, res_way_reg,
                                        tag_reg, set_reg, res_hit_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsl_reg         <= BSL_W'(6);
            interleaved_reg <= 1'b0;
            mod_count_reg   <= CNT_MOD_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BLOCK_SIZE_LOG:   bsl_reg         <= cfg_data[BSL_W-1:0];
                CFG_INTERLEAVED_MODE: interleaved_reg <= cfg_data[0];
                CFG_MODULE_COUNT:     mod_count_reg   <= cfg_data[CNT_MOD_W-1:0];
                default:              ;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_div_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV))
        else $error("divider started without sequencer waiting on it");

    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> $past(state_reg == ST_RD))
        else $error("way compare without a read issued the cycle before");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_data_reg[0]) |-> (m_data_reg[44:39] == '0))
        else $error("miss or write result carries nonzero way fields");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

import ctl_pkg::*;

// s_axis_tdata layout, lowest bits last
typedef struct packed {
    logic [2:0]        pad;
    logic              new_lock;
    logic [ADDR_W-1:0] new_transient_tag;
    logic              new_prefetched;
    logic [2:0]        new_state;
    logic [WAY_W-1:0]  way_sel;
    logic [SET_W-1:0]  set_sel;
    logic [ADDR_W-1:0] address;
} req_beat_t;

// m_axis_tdata layout, lowest bits last
typedef struct packed {
    logic [2:0]        pad;
    logic              was_prefetched;
    logic [2:0]        block_state;
    logic [WAY_W-1:0]  hit_way;
    logic [ADDR_W-1:0] block_tag;
    logic [SET_W-1:0]  set_index;
    logic              hit;
} lookup_rsp_t;

class tag_lookup_checker;
    entry_t               tag_mirror [ENTRIES];
    logic [BSL_W-1:0]     bsl;
    logic                 interleaved;
    logic [CNT_MOD_W-1:0] modules;
    lookup_rsp_t          awaited_rsp [$];
    int                   errors;

    function new();
        bsl = 4'd6;
        interleaved = 1'b0;
        modules = 7'd1;
        errors = 0;
        foreach (tag_mirror[i])
            tag_mirror[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BLOCK_SIZE_LOG:   bsl = data[BSL_W-1:0];
            CFG_INTERLEAVED_MODE: interleaved = data[0];
            CFG_MODULE_COUNT:     modules = data;
            default: ;
        endcase
    endfunction

    // block tag and set index of a byte address under the current settings
    function void locate(input logic [ADDR_W-1:0] addr, output logic [ADDR_W-1:0] tag,
                         output logic [SET_W-1:0] set_idx);
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] div;
        logic [ADDR_W-1:0] rem;
        mask = (32'd1 << bsl) - 32'd1;
        tag = addr & ~mask;
        blk = tag >> bsl;
        div = (modules == 0) ? 32'd1 : {25'd0, modules};
        if (interleaved)
            blk = blk / div;
        rem = blk % SETS;
        set_idx = rem[SET_W-1:0];
    endfunction

    function void apply_item(logic cmd, req_beat_t b);
        lookup_rsp_t       rsp;
        logic [ADDR_W-1:0] tag;
        logic [SET_W-1:0]  si;
        entry_t            ent;
        int                e;
        logic              found;
        rsp = '0;
        if (cmd == CMD_WRITE) begin
            if (b.set_sel < SETS && b.way_sel < WAYS) begin
                e = int'(b.set_sel) * WAYS + int'(b.way_sel);
                tag_mirror[e].tag        = b.address;
                tag_mirror[e].state      = b.new_state;
                tag_mirror[e].prefetched = b.new_prefetched;
                tag_mirror[e].transient  = b.new_transient_tag;
                tag_mirror[e].lock       = b.new_lock;
            end
        end else begin
            locate(b.address, tag, si);
            rsp.set_index = si;
            rsp.block_tag = tag;
            found = 1'b0;
            for (int w = 0; w < WAYS; w++) begin
                ent = tag_mirror[int'(si) * WAYS + w];
                if (!found && ((ent.tag == tag && ent.state != 0) ||
                               (ent.transient == tag && ent.lock))) begin
                    found = 1'b1;
                    rsp.hit = 1'b1;
                    rsp.hit_way = w[WAY_W-1:0];
                    rsp.block_state = ent.state;
                    rsp.was_prefetched = ent.prefetched;
                end
            end
        end
        awaited_rsp.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s expected 0x%0h actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(lookup_rsp_t got);
        lookup_rsp_t want;
        if (awaited_rsp.size() == 0) begin
            $error("result 0x%0h with no item outstanding", got);
            errors++;
            return;
        end
        want = awaited_rsp.pop_front();
        compare_field("hit", 32'(want.hit), 32'(got.hit));
        compare_field("set_index", 32'(want.set_index), 32'(got.set_index));
        compare_field("block_tag", want.block_tag, got.block_tag);
        compare_field("hit_way", 32'(want.hit_way), 32'(got.hit_way));
        compare_field("block_state", 32'(want.block_state), 32'(got.block_state));
        compare_field("was_prefetched", 32'(want.was_prefetched),
                      32'(got.was_prefetched));
    endfunction

    function int pending();
        return awaited_rsp.size();
    endfunction
endclass

module tb_top;

    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 236;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tag_lookup_checker sb = new();

    int                idle_pct = 20;
    int                stall_pct = 8;
    int                quiet_cycles = 0;
    logic [ADDR_W-1:0] known_tags [$];

    cache_tag_lookup_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.apply_item(s_axis_tuser[0], s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("cache_tag_lookup_top regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // valid stays high across back-to-back items
    task automatic send(input logic cmd, input req_beat_t beat);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic lookup(input logic [ADDR_W-1:0] addr);
        req_beat_t beat;
        beat = '0;
        beat.address = addr;
        beat.set_sel = SET_W'($urandom);
        beat.way_sel = WAY_W'($urandom);
        beat.new_state = 3'($urandom);
        beat.new_prefetched = 1'($urandom);
        beat.new_transient_tag = $urandom;
        beat.new_lock = 1'($urandom);
        send(CMD_LOOKUP, beat);
    endtask

    task automatic write_entry(input logic [SET_W-1:0] set_idx, input logic [WAY_W-1:0] way,
                               input logic [ADDR_W-1:0] tag, input logic [2:0] state,
                               input logic pf, input logic [ADDR_W-1:0] trans, input logic lock);
        req_beat_t beat;
        beat = '0;
        beat.address = tag;
        beat.set_sel = set_idx;
        beat.way_sel = way;
        beat.new_state = state;
        beat.new_prefetched = pf;
        beat.new_transient_tag = trans;
        beat.new_lock = lock;
        send(CMD_WRITE, beat);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // upper data bits beyond each register's width are random and must be dropped
    task automatic configure(input int bsl, input int mode, input int mcount, input logic extra);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[BSL_W-1:0] = bsl[BSL_W-1:0];
        write_reg(CFG_BLOCK_SIZE_LOG, d);
        d = CFG_DATA_W'($urandom);
        d[0] = mode[0];
        write_reg(CFG_INTERLEAVED_MODE, d);
        write_reg(CFG_MODULE_COUNT, mcount[CFG_DATA_W-1:0]);
        if (extra)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly entries placed where a lookup will find them, the rest noise
    task automatic random_item(output logic cmd, output req_beat_t beat);
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] mask;
        logic [SET_W-1:0]  si;
        int                pick;
        beat = '0;
        cmd = ($urandom_range(0, 99) < 35) ? CMD_WRITE : CMD_LOOKUP;
        beat.address = $urandom;
        beat.set_sel = SET_W'($urandom);
        beat.way_sel = WAY_W'($urandom);
        beat.new_state = 3'($urandom);
        beat.new_prefetched = 1'($urandom);
        beat.new_transient_tag = $urandom;
        beat.new_lock = 1'($urandom);
        mask = (32'd1 << sb.bsl) - 32'd1;
        if (cmd == CMD_WRITE)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                sb.locate(beat.address, tag, si);
                beat.set_sel = si;
                pick = $urandom_range(0, 2);
                if (pick != 1)
                    beat.address = tag;
                if (pick != 0)
                begin
                    beat.new_transient_tag = tag;
                    beat.new_lock = 1'b1;
                end
                if (known_tags.size() >= 16)
                    void'(known_tags.pop_front());
                known_tags.push_back(tag);
            end
        end
        else if (known_tags.size() != 0 && $urandom_range(0, 9) < 7)
        begin
            tag = known_tags[$urandom_range(0, known_tags.size() - 1)];
            beat.address = tag | ($urandom & mask);
        end
    endtask

    initial
    begin
        int        ph_bsl [PHASES] = '{2, 12, 0, 15, 13, 1, 9, 6};
        int        ph_mode [PHASES] = '{0, 1, 1, 0, 1, 1, 1, 1};
        int        ph_mc [PHASES] = '{1, 64, 0, 127, 127, 3, 5, 7};
        logic      cmd;
        req_beat_t beat;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 64-byte blocks, bounds mode
        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
        write_entry(6'd1, 2'd2, 32'h0000_0040, 3'd5, 1'b1, 32'h0, 1'b0);
        lookup(32'h0000_007F);
        // locked transient match with invalid state wins in a lower way
        write_entry(6'd1, 2'd0, 32'h0000_0040, 3'd0, 1'b0, 32'h0000_0040, 1'b1);
        lookup(32'h0000_0040);
        write_entry(6'd1, 2'd1, 32'h0000_0040, 3'd7, 1'b0, 32'h0, 1'b0);
        lookup(32'h0000_0055);
        // stored tag with offset bits never matches
        write_entry(6'd2, 2'd3, 32'h0000_0085, 3'd1, 1'b0, 32'h0, 1'b0);
        lookup(32'h0000_0085);
        // transient match without lock, tag match with invalid state
        write_entry(6'd3, 2'd0, 32'h0000_00C0, 3'd0, 1'b1, 32'h0000_00C0, 1'b0);
        lookup(32'h0000_00C0);
        write_entry(6'd63, 2'd3, 32'hFFFF_FFC0, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
        lookup(32'hFFFF_FFFF);
        write_entry(6'd0, 2'd0, 32'h0000_0000, 3'd1, 1'b0, 32'hFFFF_FFFF, 1'b0);
        lookup(32'h0000_003F);
        // lock held but transient tag differs
        write_entry(6'd4, 2'd0, 32'h0000_0100, 3'd0, 1'b1, 32'h0000_0500, 1'b1);
        write_entry(6'd4, 2'd1, 32'h0000_0100, 3'd2, 1'b1, 32'h0, 1'b0);
        lookup(32'h0000_013C);
        lookup(32'h0000_0500);
        write_entry(6'd20, 2'd2, 32'h0000_0500, 3'd4, 1'b0, 32'h0000_0500, 1'b1);
        lookup(32'h0000_0501);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_pipe();
            if (p == 6)
            begin
                ph_bsl[p] = $urandom_range(2, 12);
                ph_mc[p] = $urandom_range(1, 64);
            end
            configure(ph_bsl[p], ph_mode[p], ph_mc[p], p == 3);
            known_tags.delete();
            idle_pct = (p == PHASES - 1) ? 0 : ((p % 2) ? 20 : 4);
            stall_pct = (p == PHASES - 1) ? 0 : ((p % 2) ? 3 : 10);
            repeat (PHASE_ITEMS)
            begin
                random_item(cmd, beat);
                send(cmd, beat);
            end
        end

        drain_pipe();
        if (sb.errors == 0)
            $display("cache_tag_lookup_top regression: pass");
        else
            $display("cache_tag_lookup_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
